// File: hdl/secant_root_step_engine_core_assert.svh
// assertion macros for the checker file
`ifndef SECANT_ROOT_STEP_ENGINE_CORE_ASSERT_SVH
`define SECANT_ROOT_STEP_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define SRSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srse assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define SRSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srse assertion failed");

`endif

// File: hdl/srse_pkg.sv
// ============================================================================
// srse_pkg
// Types and constants of the secant root step engine.
// ============================================================================
package srse_pkg;

    // result status codes
    typedef enum logic [2:0] {
        STS_EVAL    = 3'd0,
        STS_CONV    = 3'd1,
        STS_FLAT    = 3'd2,
        STS_DEGEN   = 3'd3,
        STS_NONFIN  = 3'd4,
        STS_DIVERGE = 3'd5,
        STS_LIMIT   = 3'd6
    } t_status;

    // input item action codes
    typedef enum logic {
        ACT_START = 1'b0,
        ACT_VALUE = 1'b1
    } t_action;

    // configuration register indexes
    typedef enum logic {
        REG_TOL   = 1'b0,
        REG_LIMIT = 1'b1
    } t_reg_idx;

    // sequencer states of the top level
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DF,
        ST_DX,
        ST_SLOPE,
        ST_Q,
        ST_XN,
        ST_DONE
    } t_state;

    // shared floating-point unit operations
    typedef enum logic {
        FOP_SUB,
        FOP_DIV
    } t_fop;

    // floating-point unit states
    typedef enum logic [3:0] {
        FS_IDLE,
        FS_ADD_ALIGN,
        FS_ADD_SUM,
        FS_NORM,
        FS_DIV_PRE,
        FS_DIV_LOOP,
        FS_DIV_FIX,
        FS_ROUND,
        FS_DONE
    } t_fstate;

    // request into the floating-point unit
    typedef struct packed {
        logic start;
        t_fop op;
    } t_fpu_req;

    localparam logic [63:0] TOL_RESET     = 64'd4517329193108106637;
    localparam logic [15:0] LIMIT_RESET   = 16'd1000;
    localparam logic [63:0] FLAT_EPS      = 64'h3CD203AF9EE75616;
    localparam logic [63:0] DIVERGE_BOUND = 64'h4202A05F20000000;
    localparam logic [63:0] CANON_NAN     = 64'h7FF8000000000000;
    localparam logic [5:0]  QUO_LAST      = 6'd55;

endpackage

// File: hdl/srse_fpu.sv
// ============================================================================
// srse_fpu
// Shared binary64 subtract and divide unit, round to nearest even, with
// subnormals; normalizing and quotient bits go one bit per cycle.
// ============================================================================
module srse_fpu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srse_pkg::t_fpu_req i_req,
    input  logic [63:0]        i_a,
    input  logic [63:0]        i_b,
    output logic               o_done,
    output logic [63:0]        o_res
);
    import srse_pkg::*;

    // shift right keeping the lost bits as a sticky lsb
    function automatic logic [55:0] shr_sticky(input logic [55:0] m, input logic [12:0] sh);
        logic [55:0] mask;
        logic [55:0] r;
        mask = '0;
        if (sh >= 13'd56) begin
            r = {55'd0, |m};
        end else begin
            mask = ~({56{1'b1}} << sh[5:0]);
            r    = (m >> sh[5:0]) | {55'd0, |(m & mask)};
        end
        return r;
    endfunction

    // round to nearest even and pack; leading one at bit 55 unless subnormal
    function automatic logic [63:0] round_pack(input logic s, input logic signed [12:0] e,
                                               input logic [55:0] m);
        logic [53:0]        mant;
        logic signed [12:0] e2;
        logic               up;
        logic [10:0]        fld;
        logic [63:0]        r;
        up   = m[2] & (m[3] | m[1] | m[0]);
        mant = {1'b0, m[55:3]} + {53'd0, up};
        e2   = e;
        if (mant[53]) begin
            mant = {1'b0, mant[53:1]};
            e2   = e + 13'sd1;
        end
        fld = mant[52] ? e2[10:0] : 11'd0;
        if (e2 >= 13'sd2047) begin
            r = {s, 11'h7FF, 52'd0};
        end else begin
            r = {s, fld, mant[51:0]};
        end
        return r;
    endfunction

    t_fstate            r_fs, n_fs;
    logic [63:0]        r_a, r_b, r_res;
    logic               r_sign, r_sub;
    logic signed [12:0] r_e, r_eb;
    logic [55:0]        r_m, r_ms;
    logic [52:0]        r_ma, r_mb;
    logic [54:0]        r_rem;
    logic [5:0]         r_cnt;

    // operand classification at issue
    logic [63:0] w_bn;
    logic        w_a_nan, w_b_nan, w_a_inf, w_b_inf, w_a_zero, w_b_zero;
    logic        w_spec;
    logic [63:0] w_spec_res;
    logic        w_sdiv;

    always_comb begin
        w_bn     = (i_req.op == FOP_SUB) ? {~i_b[63], i_b[62:0]} : i_b;
        w_a_nan  = (&i_a[62:52]) & (|i_a[51:0]);
        w_b_nan  = (&i_b[62:52]) & (|i_b[51:0]);
        w_a_inf  = (&i_a[62:52]) & ~(|i_a[51:0]);
        w_b_inf  = (&i_b[62:52]) & ~(|i_b[51:0]);
        w_a_zero = (i_a[62:0] == 63'd0);
        w_b_zero = (i_b[62:0] == 63'd0);
        w_sdiv   = i_a[63] ^ i_b[63];
        w_spec     = 1'b0;
        w_spec_res = CANON_NAN;
        if (i_req.op == FOP_SUB) begin
            if (w_a_nan || w_b_nan || (w_a_inf && w_b_inf && (i_a[63] != w_bn[63]))) begin
                w_spec = 1'b1;
            end else if (w_a_inf) begin
                w_spec     = 1'b1;
                w_spec_res = i_a;
            end else if (w_b_inf) begin
                w_spec     = 1'b1;
                w_spec_res = w_bn;
            end else if (w_a_zero && w_b_zero) begin
                w_spec     = 1'b1;
                w_spec_res = {i_a[63] & w_bn[63], 63'd0};
            end
        end else begin
            if (w_a_nan || w_b_nan || (w_a_inf && w_b_inf) || (w_a_zero && w_b_zero)) begin
                w_spec = 1'b1;
            end else if (w_a_inf || w_b_zero) begin
                w_spec     = 1'b1;
                w_spec_res = {w_sdiv, 11'h7FF, 52'd0};
            end else if (w_a_zero || w_b_inf) begin
                w_spec     = 1'b1;
                w_spec_res = {w_sdiv, 63'd0};
            end
        end
    end

    // alignment of the add path
    logic [10:0] w_ea, w_eb, w_d;
    logic [52:0] w_ma, w_mb;
    logic        w_a_big;

    always_comb begin
        w_ea    = (r_a[62:52] == 11'd0) ? 11'd1 : r_a[62:52];
        w_eb    = (r_b[62:52] == 11'd0) ? 11'd1 : r_b[62:52];
        w_ma    = {(r_a[62:52] != 11'd0), r_a[51:0]};
        w_mb    = {(r_b[62:52] != 11'd0), r_b[51:0]};
        w_a_big = (w_ea > w_eb) || ((w_ea == w_eb) && (w_ma >= w_mb));
        w_d     = w_a_big ? (w_ea - w_eb) : (w_eb - w_ea);
    end

    // add, normalize and divide step logic
    logic [56:0]        w_sum;
    logic               w_norm_go;
    logic               w_pre_ok, w_ma_lt;
    logic signed [12:0] w_ediv;
    logic               w_ge;
    logic [54:0]        w_rem_sub;

    always_comb begin
        w_sum     = r_sub ? ({1'b0, r_m} - {1'b0, r_ms}) : ({1'b0, r_m} + {1'b0, r_ms});
        w_norm_go = !r_m[55] && (r_e > 13'sd1);
        w_pre_ok  = r_ma[52] && r_mb[52];
        w_ma_lt   = r_ma < r_mb;
        w_ediv    = r_e - r_eb + 13'sd1023 - (w_ma_lt ? 13'sd1 : 13'sd0);
        w_ge      = r_rem >= {2'b00, r_mb};
        w_rem_sub = w_ge ? (r_rem - {2'b00, r_mb}) : r_rem;
    end

    // next state
    always_comb begin
        n_fs = r_fs;
        case (r_fs)
            FS_IDLE, FS_DONE: begin
                if (i_req.start) begin
                    if (w_spec) begin
                        n_fs = FS_DONE;
                    end else if (i_req.op == FOP_SUB) begin
                        n_fs = FS_ADD_ALIGN;
                    end else begin
                        n_fs = FS_DIV_PRE;
                    end
                end else begin
                    n_fs = FS_IDLE;
                end
            end
            FS_ADD_ALIGN: n_fs = FS_ADD_SUM;
            FS_ADD_SUM:   n_fs = (w_sum == 57'd0) ? FS_DONE : FS_NORM;
            FS_NORM:      n_fs = w_norm_go ? FS_NORM : FS_ROUND;
            FS_DIV_PRE:   n_fs = w_pre_ok ? FS_DIV_LOOP : FS_DIV_PRE;
            FS_DIV_LOOP:  n_fs = (r_cnt == QUO_LAST) ? FS_DIV_FIX : FS_DIV_LOOP;
            FS_DIV_FIX:   n_fs = FS_ROUND;
            FS_ROUND:     n_fs = FS_DONE;
            default:      n_fs = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_fs == FS_DONE);
        o_res  = r_res;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= FS_IDLE;
        end else begin
            r_fs <= n_fs;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_fs)
            FS_IDLE, FS_DONE: begin
                if (i_req.start) begin
                    r_a    <= i_a;
                    r_b    <= w_bn;
                    r_res  <= w_spec_res;
                    r_sign <= w_sdiv;
                    r_ma   <= {(i_a[62:52] != 11'd0), i_a[51:0]};
                    r_mb   <= {(i_b[62:52] != 11'd0), i_b[51:0]};
                    r_e    <= $signed({2'b00, (i_a[62:52] == 11'd0) ? 11'd1 : i_a[62:52]});
                    r_eb   <= $signed({2'b00, (i_b[62:52] == 11'd0) ? 11'd1 : i_b[62:52]});
                end
            end
            FS_ADD_ALIGN: begin
                r_m    <= {(w_a_big ? w_ma : w_mb), 3'b000};
                r_ms   <= shr_sticky({(w_a_big ? w_mb : w_ma), 3'b000}, {2'b00, w_d});
                r_e    <= $signed({2'b00, (w_a_big ? w_ea : w_eb)});
                r_sign <= w_a_big ? r_a[63] : r_b[63];
                r_sub  <= r_a[63] ^ r_b[63];
            end
            FS_ADD_SUM: begin
                if (w_sum == 57'd0) begin
                    r_res <= 64'd0;
                end else if (w_sum[56]) begin
                    r_m <= {w_sum[56:2], w_sum[1] | w_sum[0]};
                    r_e <= r_e + 13'sd1;
                end else begin
                    r_m <= w_sum[55:0];
                end
            end
            FS_NORM: begin
                if (w_norm_go) begin
                    r_m <= {r_m[54:0], 1'b0};
                    r_e <= r_e - 13'sd1;
                end
            end
            FS_DIV_PRE: begin
                if (w_pre_ok) begin
                    r_e   <= w_ediv;
                    r_rem <= w_ma_lt ? {1'b0, r_ma, 1'b0} : {2'b00, r_ma};
                    r_cnt <= 6'd0;
                    r_m   <= 56'd0;
                end else begin
                    if (!r_ma[52]) begin
                        r_ma <= {r_ma[51:0], 1'b0};
                        r_e  <= r_e - 13'sd1;
                    end
                    if (!r_mb[52]) begin
                        r_mb <= {r_mb[51:0], 1'b0};
                        r_eb <= r_eb - 13'sd1;
                    end
                end
            end
            FS_DIV_LOOP: begin
                r_rem <= {w_rem_sub[53:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == QUO_LAST) begin
                    r_m <= {r_m[54:0], w_ge | (w_rem_sub != 55'd0)};
                end else begin
                    r_m <= {r_m[54:0], w_ge};
                end
            end
            FS_DIV_FIX: begin
                // subnormal quotient: denormalize before the single rounding
                if (r_e < 13'sd1) begin
                    r_m <= shr_sticky(r_m, 13'(13'sd1 - r_e));
                    r_e <= 13'sd1;
                end
            end
            FS_ROUND: begin
                r_res <= round_pack(r_sign, r_e, r_m);
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/secant_root_step_engine_core.sv
// ============================================================================
// secant_root_step_engine_core
// Secant root search step in binary64: takes function values from outside
// and returns the next point to evaluate or the end of the search.
// ============================================================================
//
//  channel   handshake                    payload
//  --------  ---------------------------  -------------------------------------
//  in        i_in_valid / o_in_ready      i_action, i_x_current, i_x_previous,
//                                         i_f_current, i_f_previous
//  out       o_out_valid / i_out_ready    o_status, o_x_out, o_error_out,
//                                         o_iteration_count
//  cfg       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  An item goes from the check state straight to the done state when the limit or
//  tolerance ends it, otherwise it takes up to three subtracts and two divides
//  in the shared floating-point unit, which produces one quotient bit and one
//  normalizing shift per cycle; divides take longer with subnormal operands.
//  o_in_ready is low from an accepted item that starts a step until its result
//  is in the output register; a result waiting on i_out_ready holds the next
//  one back. A value item while no search is active is taken and dropped.
//  Synchronous active-low reset; no clearing pass. cfg writes are always taken.
//
module secant_root_step_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [63:0] i_x_current,
    input  logic [63:0] i_x_previous,
    input  logic [63:0] i_f_current,
    input  logic [63:0] i_f_previous,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_x_out,
    output logic [63:0] o_error_out,
    output logic [15:0] o_iteration_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import srse_pkg::*;

    // binary64 less-than, false on nan, equal zeros compare equal
    function automatic logic flt_lt(input logic [63:0] a, input logic [63:0] b);
        logic        a_nan, b_nan, zz;
        logic [63:0] ka, kb;
        a_nan = (&a[62:52]) & (|a[51:0]);
        b_nan = (&b[62:52]) & (|b[51:0]);
        zz    = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        ka    = a[63] ? ~a : {1'b1, a[62:0]};
        kb    = b[63] ? ~b : {1'b1, b[62:0]};
        return !a_nan && !b_nan && !zz && (ka < kb);
    endfunction

    t_state      r_state, n_state;
    logic [63:0] r_tol;
    logic [15:0] r_limit, r_upd;
    logic        r_active, r_out_vld;
    logic [63:0] r_x, r_v, r_xb, r_vb, r_pend, r_df, r_xsel;
    t_status     r_stat;
    t_status     r_o_status;
    logic [63:0] r_o_x, r_o_err;
    logic [15:0] r_o_cnt;

    t_fpu_req    w_req;
    logic [63:0] w_fa, w_fb, w_fres;
    logic        w_fdone;
    logic        w_fin;
    t_status     w_fin_stat;
    logic [63:0] w_fin_x;
    logic        w_in_acc, w_out_free;
    logic [63:0] w_fres_abs;

    // shared floating-point unit
    srse_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_fa),
        .i_b     (w_fb),
        .o_done  (w_fdone),
        .o_res   (w_fres)
    );

    assign w_in_acc   = (r_state == ST_IDLE) && i_in_valid;
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_fres_abs = {1'b0, w_fres[62:0]};

    // step decisions and unit requests
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = FOP_SUB;
        w_fa        = r_v;
        w_fb        = r_vb;
        w_fin       = 1'b0;
        w_fin_stat  = STS_EVAL;
        w_fin_x     = r_x;
        case (r_state)
            ST_CHECK: begin
                if (r_upd >= r_limit) begin
                    w_fin      = 1'b1;
                    w_fin_stat = STS_LIMIT;
                end else if (flt_lt({1'b0, r_v[62:0]}, r_tol)) begin
                    w_fin      = 1'b1;
                    w_fin_stat = STS_CONV;
                end else begin
                    w_req.start = 1'b1;
                end
            end
            ST_DF: begin
                if (w_fdone) begin
                    if (flt_lt(w_fres_abs, FLAT_EPS)) begin
                        w_fin      = 1'b1;
                        w_fin_stat = STS_FLAT;
                    end else begin
                        w_req.start = 1'b1;
                        w_fa        = r_x;
                        w_fb        = r_xb;
                    end
                end
            end
            ST_DX: begin
                if (w_fdone) begin
                    if (flt_lt(w_fres_abs, FLAT_EPS)) begin
                        w_fin      = 1'b1;
                        w_fin_stat = STS_DEGEN;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.op    = FOP_DIV;
                        w_fa        = r_df;
                        w_fb        = w_fres;
                    end
                end
            end
            ST_SLOPE: begin
                if (w_fdone) begin
                    // zero slope counts as a non-finite step
                    if (w_fres[62:0] == 63'd0) begin
                        w_fin      = 1'b1;
                        w_fin_stat = STS_NONFIN;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.op    = FOP_DIV;
                        w_fa        = r_v;
                        w_fb        = w_fres;
                    end
                end
            end
            ST_Q: begin
                if (w_fdone) begin
                    w_req.start = 1'b1;
                    w_fa        = r_x;
                    w_fb        = w_fres;
                end
            end
            ST_XN: begin
                if (w_fdone) begin
                    w_fin = 1'b1;
                    if (&w_fres[62:52]) begin
                        w_fin_stat = STS_NONFIN;
                    end else if (flt_lt(DIVERGE_BOUND, w_fres_abs)) begin
                        w_fin_stat = STS_DIVERGE;
                    end else begin
                        w_fin_stat = STS_EVAL;
                        w_fin_x    = w_fres;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && ((i_action == ACT_START) || r_active)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: n_state = w_fin ? ST_DONE : ST_DF;
            ST_DF: begin
                if (w_fdone) begin
                    n_state = w_fin ? ST_DONE : ST_DX;
                end
            end
            ST_DX: begin
                if (w_fdone) begin
                    n_state = w_fin ? ST_DONE : ST_SLOPE;
                end
            end
            ST_SLOPE: begin
                if (w_fdone) begin
                    n_state = w_fin ? ST_DONE : ST_Q;
                end
            end
            ST_Q: begin
                if (w_fdone) begin
                    n_state = ST_XN;
                end
            end
            ST_XN: begin
                if (w_fdone) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tol     <= TOL_RESET;
            r_limit   <= LIMIT_RESET;
            r_upd     <= 16'd0;
            r_active  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_TOL:   r_tol   <= i_cfg_data;
                    REG_LIMIT: r_limit <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            // item intake
            if (w_in_acc) begin
                if (i_action == ACT_START) begin
                    r_upd    <= 16'd0;
                    r_active <= 1'b1;
                end else if (r_active) begin
                    r_upd <= r_upd + 16'd1;
                end
            end
            // output register
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_vld <= 1'b1;
                if (r_stat != STS_EVAL) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // search history and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (i_action == ACT_START) begin
                r_x    <= i_x_current;
                r_xb   <= i_x_previous;
                r_v    <= i_f_current;
                r_vb   <= i_f_previous;
                r_pend <= 64'd0;
            end else if (r_active) begin
                r_xb <= r_x;
                r_vb <= r_v;
                r_x  <= r_pend;
                r_v  <= i_f_current;
            end
        end
        if ((r_state == ST_DF) && w_fdone) begin
            r_df <= w_fres;
        end
        if (w_fin) begin
            r_stat <= w_fin_stat;
            r_xsel <= w_fin_x;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_o_status <= r_stat;
            r_o_x      <= r_xsel;
            r_o_err    <= {1'b0, r_v[62:0]};
            r_o_cnt    <= r_upd;
            if (r_stat == STS_EVAL) begin
                r_pend <= r_xsel;
            end
        end
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_vld;
    assign o_status          = r_o_status;
    assign o_x_out           = r_o_x;
    assign o_error_out       = r_o_err;
    assign o_iteration_count = r_o_cnt;

endmodule

// File: hdl/srse_checker.sv
// ============================================================================
// srse_checker
// Port-level checks of the secant root step engine, bound to the top level.
// ============================================================================
`include "secant_root_step_engine_core_assert.svh"

module srse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_action,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [63:0] o_x_out
);
    import srse_pkg::*;

    // a waiting result holds still until taken
    `SRSE_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_x_out) && $stable(o_status))

    // an accepted start item always leaves the block busy in the next cycle
    `SRSE_ASSERT_NXT(a_start_busy, i_in_valid && o_in_ready && (i_action == ACT_START), !o_in_ready)

    // a requested point is finite and within the divergence bound
    `SRSE_ASSERT_IMP(a_eval_bound, o_out_valid && (o_status == STS_EVAL), o_x_out[62:0] <= DIVERGE_BOUND[62:0])

endmodule

bind secant_root_step_engine_core srse_checker u_srse_checker (.*);

// File: dv/tb_secant_root_step_engine_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_secant_root_step_engine_core
// Self-checking bench for the secant root step engine. A real-valued predictor
// tracks the search and the register settings. Most items follow well-formed
// searches on random functions, evaluated at the points the block asks for.
// The rest are broken or special operands. Both channels idle at random.
// ============================================================================
module tb_secant_root_step_engine_core;
    import srse_pkg::*;

    localparam logic [63:0] ABS_BITS  = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [63:0] EXP_BITS  = 64'h7FF0000000000000;
    localparam int          WATCHDOG  = 20000;
    localparam int          DRAIN     = 400;
    localparam int          HOLD_LONG = 3000;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] x_out;
        logic [63:0] err;
        logic [15:0] count;
    } t_step_result;

    // predictor of the search and store of the results it owes
    class step_scoreboard;
        logic [63:0]  tol_bits;
        logic [15:0]  limit;
        logic [63:0]  x_now, f_now, x_before, f_before, next_point;
        logic [15:0]  updates;
        bit           active;
        int           failures;
        t_step_result owed[$];

        function void clear();
            tol_bits   = TOL_RESET;
            limit      = LIMIT_RESET;
            x_now      = '0;
            f_now      = '0;
            x_before   = '0;
            f_before   = '0;
            next_point = '0;
            updates    = '0;
            active     = 0;
            failures   = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [63:0] data);
            if (idx == REG_TOL) tol_bits = data;
            else limit = data[15:0];
        endfunction

        function real mag(logic [63:0] b);
            return $bitstoreal(b & ABS_BITS);
        endfunction

        function void owe(t_status st, logic [63:0] x);
            t_step_result r;
            r.status = st;
            r.x_out  = x;
            r.err    = f_now & ABS_BITS;
            r.count  = updates;
            owed.push_back(r);
            if (st != STS_EVAL) active = 0;
        endfunction

        // secant decision after the history has been loaded
        function void step_decide();
            real         df, dx, slope, xn;
            logic [63:0] xn_bits;
            if (updates >= limit) begin
                owe(STS_LIMIT, x_now);
                return;
            end
            if (mag(f_now) < $bitstoreal(tol_bits)) begin
                owe(STS_CONV, x_now);
                return;
            end
            df = $bitstoreal(f_now) - $bitstoreal(f_before);
            if (mag($realtobits(df)) < $bitstoreal(FLAT_EPS)) begin
                owe(STS_FLAT, x_now);
                return;
            end
            dx = $bitstoreal(x_now) - $bitstoreal(x_before);
            if (mag($realtobits(dx)) < $bitstoreal(FLAT_EPS)) begin
                owe(STS_DEGEN, x_now);
                return;
            end
            slope = df / dx;
            if (slope == 0.0) begin
                owe(STS_NONFIN, x_now);
                return;
            end
            xn      = $bitstoreal(x_now) - $bitstoreal(f_now) / slope;
            xn_bits = $realtobits(xn);
            if ((xn_bits & EXP_BITS) == EXP_BITS) begin
                owe(STS_NONFIN, x_now);
                return;
            end
            if (mag(xn_bits) > $bitstoreal(DIVERGE_BOUND)) begin
                owe(STS_DIVERGE, x_now);
                return;
            end
            next_point = xn_bits;
            owe(STS_EVAL, xn_bits);
        endfunction

        function void note_input(t_action act, logic [63:0] xc, logic [63:0] xp,
                                 logic [63:0] fc, logic [63:0] fp);
            if (act == ACT_START) begin
                x_now      = xc;
                x_before   = xp;
                f_now      = fc;
                f_before   = fp;
                next_point = '0;
                updates    = '0;
                active     = 1;
            end else begin
                if (!active) return;
                x_before = x_now;
                f_before = f_now;
                x_now    = next_point;
                f_now    = fc;
                updates  = updates + 16'd1;
            end
            step_decide();
        endfunction

        function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
                failures++;
            end
        endfunction

        function void check(logic [2:0] st, logic [63:0] x, logic [63:0] err,
                            logic [15:0] cnt);
            t_step_result e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result, expected none actual status %0d x %h",
                         $time, st, x);
                failures++;
                return;
            end
            e = owed.pop_front();
            field_check("status", e.status, st);
            field_check("x_out", e.x_out, x);
            field_check("error_out", e.err, err);
            field_check("iteration_count", e.count, cnt);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [63:0] i_x_current;
    logic [63:0] i_x_previous;
    logic [63:0] i_f_current;
    logic [63:0] i_f_previous;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [63:0] o_x_out;
    logic [63:0] o_error_out;
    logic [15:0] o_iteration_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    secant_root_step_engine_core DUT (.*);

    step_scoreboard sb;
    int  items_sent;
    bit  no_gaps;
    bit  hold_req;
    int  stall_left;
    int  quiet_cycles;

    // function under search
    int  fn_kind;
    real fn_a, fn_b, fn_r;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic real rand_real(int span);
        return (real'($urandom_range(0, 2 * span)) - real'(span)) / 100.0;
    endfunction

    function automatic real fn_eval(real x);
        case (fn_kind)
            0: return fn_a * (x - fn_r);
            1: return x * x - fn_b;
            2: return (x - fn_r) * (x - fn_r) * (x - fn_r) + fn_a * (x - fn_r);
            3: return fn_b;
            default: return 1.0 / (1.0 + x * x) - fn_b;
        endcase
    endfunction

    // operands that hit special encodings, random reals or plain random bits
    function automatic logic [63:0] odd_value();
        case ($urandom_range(0, 11))
            0: return 64'h0;
            1: return 64'h8000000000000000;
            2: return 64'h7FF0000000000000;
            3: return 64'hFFF0000000000000;
            4: return CANON_NAN;
            5: return 64'h7FEFFFFFFFFFFFFF;
            6: return 64'h0000000000000001;
            7: return 64'hFFFFFFFFFFFFFFFF;
            8: return $realtobits(rand_real(500));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(t_action act, logic [63:0] xc, logic [63:0] xp,
                             logic [63:0] fc, logic [63:0] fp);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_x_current  <= xc;
        i_x_previous <= xp;
        i_f_current  <= fc;
        i_f_previous <= fp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(act, xc, xp, fc, fp);
        items_sent++;
    endtask

    task automatic send_value(real f);
        send_item(ACT_VALUE, odd_value(), odd_value(), $realtobits(f), odd_value());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.owed.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    // start a search on a fresh function and answer until it ends or the cap
    task automatic run_search(int cap);
        real x0, x1;
        int  n;
        fn_kind = $urandom_range(0, 4);
        fn_a    = rand_real(400);
        fn_b    = real'($urandom_range(1, 900)) / 100.0;
        fn_r    = rand_real(800);
        if (fn_kind == 4) fn_b = real'($urandom_range(5, 45)) / 100.0;
        x0 = fn_r + rand_real(300);
        x1 = ($urandom_range(0, 19) == 0) ? x0 : fn_r + rand_real(300);
        send_item(ACT_START, $realtobits(x0), $realtobits(x1),
                  $realtobits(fn_eval(x0)), $realtobits(fn_eval(x1)));
        n = 0;
        while (sb.active && n < cap) begin
            send_value(fn_eval($bitstoreal(sb.next_point)));
            n++;
        end
    endtask

    task automatic noise_item();
        t_action act;
        act = $urandom_range(0, 1) ? ACT_VALUE : ACT_START;
        if ($urandom_range(0, 1))
            send_item(act, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        else
            send_item(act, odd_value(), odd_value(), odd_value(), odd_value());
    endtask

    // output side: checks, random stalls, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready  <= 1'b0;
            stall_left   = 0;
            quiet_cycles = 0;
        end else begin
            if (o_out_valid && i_out_ready)
                sb.check(o_status, o_x_out, o_error_out, o_iteration_count);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG) begin
                $display("Mismatches found");
                $finish;
            end
            if (hold_req) begin
                hold_req   = 0;
                stall_left = HOLD_LONG;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        logic [63:0] phase_tol[6];
        logic [15:0] phase_limit[6];
        int          target;
        sb = new();
        sb.clear();
        items_sent   = 0;
        no_gaps      = 0;
        hold_req     = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = ACT_START;
        i_x_current  = '0;
        i_x_previous = '0;
        i_f_current  = '0;
        i_f_previous = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_TOL;
        i_cfg_data   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: value while idle is dropped
        send_item(ACT_VALUE, '1, '1, '1, '1);
        // well-formed search on x^2 - 2
        fn_kind = 1;
        fn_b    = 2.0;
        send_item(ACT_START, $realtobits(1.5), $realtobits(1.0),
                  $realtobits(0.25), $realtobits(-1.0));
        while (sb.active) send_value(fn_eval($bitstoreal(sb.next_point)));
        // flat slope, degenerate step, nan value
        send_item(ACT_START, $realtobits(2.0), $realtobits(1.0),
                  $realtobits(3.0), $realtobits(3.0));
        send_item(ACT_START, $realtobits(2.0), $realtobits(2.0),
                  $realtobits(1.0), $realtobits(2.0));
        send_item(ACT_START, $realtobits(2.0), $realtobits(1.0), CANON_NAN,
                  $realtobits(2.0));
        // infinite step gives a zero slope
        send_item(ACT_START, 64'h7FF0000000000000, $realtobits(1.0),
                  $realtobits(1.0), $realtobits(2.0));
        // tiny slope sends the next point out of range
        send_item(ACT_START, $realtobits(1.0), $realtobits(0.0),
                  $realtobits(1.0), $realtobits(1.0 - 1e-12));
        // restart in the middle of a search
        fn_kind = 0;
        fn_a    = 3.0;
        fn_r    = 0.5;
        send_item(ACT_START, $realtobits(4.0), $realtobits(-2.0),
                  $realtobits(fn_eval(4.0)), $realtobits(fn_eval(-2.0)));
        send_value(fn_eval($bitstoreal(sb.next_point)) + 1.0);
        send_item(ACT_START, $realtobits(1.0), $realtobits(3.0),
                  $realtobits(5.0), $realtobits(-7.0));
        send_value(17.0);
        // field extremes and converged start
        send_item(ACT_START, '0, '0, '0, '0);
        send_item(ACT_START, '1, '1, '1, '1);
        send_item(ACT_START, 64'h7FEFFFFFFFFFFFFF, 64'hFFEFFFFFFFFFFFFF,
                  64'h0000000000000001, 64'h800FFFFFFFFFFFFF);
        send_item(ACT_START, 64'h0000000000000001, 64'h0000000000000003,
                  $realtobits(1.0), $realtobits(-1.0));
        drain();

        phase_tol[0] = $realtobits(1e-6);  phase_limit[0] = 16'd1000;
        phase_tol[1] = 64'h0;              phase_limit[1] = 16'hFFFF;
        phase_tol[2] = 64'hFFFFFFFFFFFFFFFF; phase_limit[2] = 16'd3;
        phase_tol[3] = $realtobits(1e-12); phase_limit[3] = 16'd0;
        phase_tol[4] = $realtobits(1e300); phase_limit[4] = 16'd8;
        phase_tol[5] = $realtobits(1e-9);  phase_limit[5] = 16'd2;

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_TOL, phase_tol[p]);
            write_reg(REG_LIMIT, phase_limit[p]);
            no_gaps = (p == 4);
            if (p == 1) hold_req = 1;
            // a search left over from the last phase runs on under the new limit
            for (int k = 0; k < 3 && sb.active; k++)
                send_value(fn_eval($bitstoreal(sb.next_point)));
            target = items_sent + 280;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) < 7) run_search($urandom_range(3, 40));
                else noise_item();
            end
            drain();
        end

        if (sb.failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
